[sv/bse_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bse_pkg
// Shared types and constants for the bubble sort engine.
// ----------------------------------------------------------------------------
package bse_pkg;

  // Width of one sorted element.
  localparam int unsigned DATA_W = 32;

  // Configuration register indexes.
  localparam logic REG_EARLY_EXIT = 1'b0;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PSTART,
    ST_PLOAD,
    ST_CMP,
    ST_PEND,
    ST_OREAD,
    ST_OLOAD,
    ST_OHOLD
  } st_t;

endpackage
`default_nettype wire

[sv/bubble_sort_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bubble_sort_engine
// Collects signed values, bubble sorts them in memory and streams them out.
// ----------------------------------------------------------------------------
// Usage:
// Values enter one beat at a time on the input channel (in_valid/in_ready,
// value, last). Each beat is stored in a DEPTH-entry memory as it is taken. Beats
// that arrive with the memory full are discarded and the run is flagged; the
// flag shows on the dropped output of every result beat of that run.
// A beat with last set closes the array. The block then stops taking input,
// bubble sorts the stored entries in place and streams them out in ascending
// order on the output channel (out_valid/out_ready, value_res, last_res,
// dropped), with last_res on the final beat. For n stored entries each sort
// pass steps through PSTART, PLOAD, its compares and PEND, with the single
// memory read port feeding one compare per cycle. With early_exit = 0 there
// are n-1 passes of n-1 compares; with early_exit = 1 each pass is one compare
// shorter and the sort stops after a pass with no swap. Read-out then steps
// through OREAD, OLOAD and OHOLD for each beat. A stall on out_ready simply
// holds the current beat; input stays blocked until the final beat is taken.
// Reset empties the array, clears the overflow flag and sets early_exit to 1.
// The early_exit register sits at byte address 0 of the APB port.
// ----------------------------------------------------------------------------
module bubble_sort_engine
  import bse_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [2:0]               paddr,
  input  wire logic [31:0]              pwdata,
  output logic      [31:0]              prdata,
  output logic                          pready,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic signed [DATA_W-1:0] value,
  input  wire logic                     last,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [DATA_W-1:0]      value_res,
  output logic                          last_res,
  output logic                          dropped
);

  logic early_exit;
  logic reg_hit;

  // Register index is the word address; only the early_exit word exists.
  assign reg_hit = (paddr[2] == REG_EARLY_EXIT);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {31'b0, early_exit} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      early_exit <= 1'b1;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      early_exit <= pwdata[0];
    end
  end

  bse_sorter #(
    .DEPTH(DEPTH)
  ) u_sorter (
    .clk       (clk),
    .rst       (rst),
    .early_exit(early_exit),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value_res (value_res),
    .last_res  (last_res),
    .dropped   (dropped)
  );

  // Input and output never overlap: a run is loaded, then sorted, then drained.
  assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input open while results are pending");

  // Taking the final result returns the block to loading.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_res) |=> in_ready)
    else $error("block did not return to loading after the final result");

  // A beat without last keeps the block loading.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !last) |=> in_ready)
    else $error("loading stopped without a last beat");

  // A beat with last closes the input until the run is drained.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && last) |=> !in_ready)
    else $error("input still open after a last beat");

endmodule
`default_nettype wire

[sv/bse_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bse_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output logic      [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[sv/bse_sorter.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bse_sorter
// Load, bubble sort and read-out sequencer around the element memory.
// ----------------------------------------------------------------------------
module bse_sorter
  import bse_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     early_exit,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic signed [DATA_W-1:0] value,
  input  wire logic                     last,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [DATA_W-1:0]      value_res,
  output logic                          last_res,
  output logic                          dropped
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  st_t state, state_next;

  logic [CW-1:0]           count;    // elements loaded so far
  logic [CW-1:0]           n;        // array length of the current run
  logic [CW-1:0]           pass;
  logic [AW-1:0]           lim;      // compares in the current pass
  logic [AW-1:0]           j;        // compare index within the pass
  logic [AW-1:0]           k;        // read-out index
  logic                    swapped;
  logic                    ovf;
  logic signed [DATA_W-1:0] carry;   // larger element bubbling up

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [DATA_W-1:0]       ram_wdata;
  logic [AW-1:0]           ram_raddr;
  logic [DATA_W-1:0]       ram_rdata;

  logic                    in_fire;
  logic                    out_fire;
  logic                    has_room;
  logic [CW-1:0]           n_new;
  logic                    gt;
  logic                    j_done;
  logic                    sort_done;
  logic                    out_done;

  bse_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign has_room  = (count < CW'(DEPTH));
  assign n_new     = has_room ? (count + CW'(1)) : count;
  assign gt        = (carry > $signed(ram_rdata));
  assign j_done    = ({1'b0, j} + (AW+1)'(1)) == {1'b0, lim};
  // A pass ends the sort after n-1 passes, or, with early_exit set, once a pass made no swap.
  assign sort_done = ((pass + CW'(1)) == (n - CW'(1))) || (early_exit && !swapped);
  assign out_done  = ({1'b0, k} + (AW+1)'(1)) == (AW+1)'(n);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire && last) begin
          state_next = (n_new < CW'(2)) ? ST_OREAD : ST_PSTART;
        end
      end
      ST_PSTART: state_next = ST_PLOAD;
      ST_PLOAD:  state_next = ST_CMP;
      ST_CMP: begin
        if (j_done) begin
          state_next = ST_PEND;
        end
      end
      ST_PEND:   state_next = sort_done ? ST_OREAD : ST_PSTART;
      ST_OREAD:  state_next = ST_OLOAD;
      ST_OLOAD:  state_next = ST_OHOLD;
      ST_OHOLD: begin
        if (out_ready) begin
          state_next = out_done ? ST_IDLE : ST_OREAD;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Memory controls and handshake outputs.
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = j;
    ram_wdata = carry;
    ram_raddr = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        ram_we    = in_valid && has_room;
        ram_waddr = count[AW-1:0];
        ram_wdata = value;
      end
      ST_PSTART: ram_raddr = '0;
      ST_PLOAD:  ram_raddr = AW'(1);
      ST_CMP: begin
        // The smaller of the pair settles at j; j+2 is fetched for the next compare.
        ram_we    = 1'b1;
        ram_waddr = j;
        ram_wdata = gt ? ram_rdata : carry;
        ram_raddr = j + AW'(2);
      end
      ST_PEND: begin
        ram_we    = 1'b1;
        ram_waddr = lim;
        ram_wdata = carry;
      end
      ST_OREAD:  ram_raddr = k;
      ST_OLOAD:  ram_raddr = k;
      ST_OHOLD:  out_valid = 1'b1;
      default:   ram_raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        if (has_room) begin
          count <= count + CW'(1);
        end else begin
          ovf <= 1'b1;
        end
      end
      if (out_fire && out_done) begin
        count <= '0;
        ovf   <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        n    <= n_new;
        pass <= '0;
        lim  <= AW'(n_new - CW'(1));
        k    <= '0;
      end
      ST_PLOAD: begin
        carry   <= $signed(ram_rdata);
        j       <= '0;
        swapped <= 1'b0;
      end
      ST_CMP: begin
        if (gt) begin
          swapped <= 1'b1;
        end else begin
          carry <= $signed(ram_rdata);
        end
        j <= j + AW'(1);
      end
      ST_PEND: begin
        pass <= pass + CW'(1);
        if (early_exit) begin
          lim <= lim - AW'(1);
        end
      end
      ST_OLOAD: begin
        value_res <= $signed(ram_rdata);
        last_res  <= out_done;
      end
      ST_OHOLD: begin
        if (out_ready) begin
          k <= k + AW'(1);
        end
      end
      default: ;
    endcase
  end

  assign dropped = ovf;

endmodule
`default_nettype wire

[bench/bse_sort_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bse_sort_checker
// Watches the bubble sort engine's channels and its register port. It keeps
// its own copy of the loading store and the mode bit and sorts each closed
// array. Every output beat is then compared with the oldest expected beat.
// ----------------------------------------------------------------------------
module bse_sort_checker
  import bse_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [2:0]               paddr,
  input  wire logic [31:0]              pwdata,
  input  wire logic [31:0]              prdata,
  input  wire logic                     pready,
  input  wire logic                     in_valid,
  input  wire logic                     in_ready,
  input  wire logic signed [DATA_W-1:0] value,
  input  wire logic                     last,
  input  wire logic                     out_valid,
  input  wire logic                     out_ready,
  input  wire logic signed [DATA_W-1:0] value_res,
  input  wire logic                     last_res,
  input  wire logic                     dropped,
  output int                            failures,
  output int                            pending
);

  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     lst;
    logic                     drp;
  } sorted_beat_t;

  sorted_beat_t             sorted_due[$];
  logic signed [DATA_W-1:0] shadow_store[DEPTH];
  int unsigned              shadow_fill;
  logic                     shadow_overflow;
  logic                     shadow_early_exit;

  initial begin
    failures = 0;
    pending  = 0;
  end

  // Only the first ten failures are described; the rest are just counted.
  task automatic log_failure(input string what);
    failures++;
    if (failures <= 10) begin
      $display("%0t: %s", $time, what);
    end
  endtask

  // Bubble sort of the shadow store, in the same pass structure as the block.
  task automatic bubble_sort_shadow(input int unsigned n);
    int unsigned              pass;
    int unsigned              j;
    int unsigned              span;
    logic                     swapped;
    logic signed [DATA_W-1:0] held;
    if (n < 2) begin
      return;
    end
    for (pass = 0; pass < n - 1; pass++) begin
      swapped = 1'b0;
      span    = shadow_early_exit ? (n - 1 - pass) : (n - 1);
      for (j = 0; j < span; j++) begin
        if (shadow_store[j] > shadow_store[j+1]) begin
          held              = shadow_store[j];
          shadow_store[j]   = shadow_store[j+1];
          shadow_store[j+1] = held;
          swapped           = 1'b1;
        end
      end
      if (shadow_early_exit && !swapped) begin
        break;
      end
    end
  endtask

  always @(posedge clk) begin
    sorted_beat_t got;
    sorted_beat_t want;
    int unsigned  k;
    if (rst) begin
      sorted_due.delete();
      shadow_fill       = 0;
      shadow_overflow   = 1'b0;
      shadow_early_exit = 1'b1;
      pending           = 0;
    end else begin
      // Register port: writes keep bit 0 of the data, other indexes are ignored.
      if (psel && penable && pready && ((paddr >> 2) == REG_EARLY_EXIT)) begin
        if (pwrite) begin
          shadow_early_exit = pwdata[0];
        end else if (prdata !== {31'b0, shadow_early_exit}) begin
          log_failure($sformatf("early_exit readback: expected %0d, got 0x%08h",
                                shadow_early_exit, prdata));
        end
      end

      if (out_valid && out_ready) begin
        got = '{val: value_res, lst: last_res, drp: dropped};
        if (sorted_due.size() == 0) begin
          log_failure($sformatf("sorted beat with none outstanding: value %0d last %0b dropped %0b",
                                got.val, got.lst, got.drp));
        end else begin
          want = sorted_due.pop_front();
          if (got !== want) begin
            log_failure($sformatf({"sorted beat mismatch: expected value %0d last %0b dropped %0b,",
                                   " got value %0d last %0b dropped %0b"},
                                  want.val, want.lst, want.drp, got.val, got.lst, got.drp));
          end
        end
      end

      if (in_valid && in_ready) begin
        if (shadow_fill < DEPTH) begin
          shadow_store[shadow_fill] = value;
          shadow_fill++;
        end else begin
          shadow_overflow = 1'b1;
        end
        if (last) begin
          bubble_sort_shadow(shadow_fill);
          for (k = 0; k < shadow_fill; k++) begin
            sorted_due.push_back('{val: shadow_store[k], lst: (k + 1 == shadow_fill),
                                   drp: shadow_overflow});
          end
          shadow_fill     = 0;
          shadow_overflow = 1'b0;
        end
      end

      pending = sorted_due.size();
    end
  end

endmodule

[bench/tb_bubble_sort_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bubble_sort_engine
// Stimulus and verdict for the bubble sort engine. A short directed part
// covers the value extremes, duplicates, a single element and an overflowing
// array. Random arrays then run in four phases with different idling on
// both channels, the mode setting alternating from phase to phase. The checker beside
// the block predicts every sorted beat and reports a failure count.
// ----------------------------------------------------------------------------
module tb_bubble_sort_engine;
  import bse_pkg::*;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned RESET_CYCLES = 8;
  // A full 16-entry sort with fixed passes and the long receiver hold-off set by
  // LONG_HOLD both fit in the quiet limit many times over.
  localparam int unsigned QUIET_LIMIT  = 6000;
  localparam int unsigned LONG_HOLD    = 400;
  // Cycles allowed after the last sorted beat before the block is called idle.
  localparam int unsigned SETTLE       = 40;
  localparam int unsigned PHASE_BEATS  = 100;

  // The early_exit register is index 0; index 1 maps to nothing.
  localparam logic [2:0] EARLY_EXIT_ADDR = {REG_EARLY_EXIT, 2'b00};
  localparam logic [2:0] UNMAPPED_ADDR   = 3'd4;

  localparam logic signed [DATA_W-1:0] MOST_NEGATIVE = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] MOST_POSITIVE = 32'sh7FFF_FFFF;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [2:0]               paddr;
  logic [31:0]              pwdata;
  logic [31:0]              prdata;
  logic                     pready;
  logic                     in_valid;
  logic                     in_ready;
  logic signed [DATA_W-1:0] value;
  logic                     last;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [DATA_W-1:0] value_res;
  logic                     last_res;
  logic                     dropped;

  int          failures;
  int          pending;
  int unsigned beats_sent = 0;
  int unsigned idle_pct   = 0;
  int unsigned stall_pct  = 0;
  int unsigned quiet      = 0;
  logic        hold_req   = 1'b0;

  always #4 clk = ~clk;

  bubble_sort_engine #(.DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value_res (value_res),
    .last_res  (last_res),
    .dropped   (dropped)
  );

  bse_sort_checker #(.DEPTH(DEPTH)) u_checker (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value_res (value_res),
    .last_res  (last_res),
    .dropped   (dropped),
    .failures  (failures),
    .pending   (pending)
  );

  // One APB transfer: a setup phase, then an access phase held until pready.
  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Offers one beat on the input channel and returns at the edge that takes
  // it. A random gap of idle cycles may come first, at the current idle rate.
  task automatic send_beat(input logic signed [DATA_W-1:0] v, input logic is_last);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do begin
        @(posedge clk);
      end while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    value    <= v;
    last     <= is_last;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    beats_sent++;
  endtask

  // Stops offering and waits until every predicted sorted beat has been
  // taken. The first edge lets the checker see the beat taken just now.
  task automatic drain();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] corner_value(input int unsigned sel);
    case (sel)
      0:       return MOST_NEGATIVE;
      1:       return MOST_POSITIVE;
      2:       return '0;
      3:       return -1;
      default: return 1;
    endcase
  endfunction

  // One array of random length and shape. Lengths favor partial fills, with
  // single elements, exact fills and overflows mixed in. The shapes give
  // fully random values, small values with many duplicates, runs that are
  // already sorted or reversed, and the value extremes.
  task automatic send_random_array();
    int unsigned len;
    int unsigned shape;
    int unsigned pick;
    int unsigned k;
    int          start;
    int          step;
    int          v;
    pick = $urandom_range(99);
    if (pick < 10) begin
      len = 1;
    end else if (pick < 22) begin
      len = DEPTH;
    end else if (pick < 32) begin
      len = DEPTH + $urandom_range(1, 4);
    end else begin
      len = $urandom_range(2, DEPTH - 1);
    end
    shape = $urandom_range(4);
    start = int'($urandom_range(2000)) - 1000;
    step  = int'($urandom_range(1, 5000));
    for (k = 0; k < len; k++) begin
      case (shape)
        0:       v = int'($urandom);
        1:       v = int'($urandom_range(16)) - 8;
        2:       v = start + int'(k) * step;
        3:       v = start - int'(k) * step;
        default: v = corner_value($urandom_range(4));
      endcase
      send_beat(v, k + 1 == len);
    end
  endtask

  // A phase of random arrays at the given idle and stall rates, ended by a
  // full drain so that the next register write finds the block idle.
  task automatic run_phase(input int unsigned idle, input int unsigned stall);
    int unsigned first;
    idle_pct  = idle;
    stall_pct = stall;
    first     = beats_sent;
    while (beats_sent - first < PHASE_BEATS) begin
      send_random_array();
    end
    drain();
  endtask

  // Receiver. It stalls at the current rate, and on request holds out_ready
  // low for a hold-off counted here from LONG_HOLD, while the sender keeps going.
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) begin
      @(posedge clk);
    end
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req <= 1'b0;
      end else begin
        out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
      end
      @(posedge clk);
    end
  end

  // Watchdog: counts cycles in which no beat and no register access moves.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int unsigned k;
    rst      <= 1'b1;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= EARLY_EXIT_ADDR;
    pwdata   <= '0;
    in_valid <= 1'b0;
    value    <= '0;
    last     <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The mode bit should read back as its reset value of 1.
    apb_access(1'b0, EARLY_EXIT_ADDR, '0);

    // Directed arrays in early-exit mode: a single element, an extreme pair
    // in reverse order, and duplicates around a negative value.
    send_beat(MOST_NEGATIVE, 1'b1);
    send_beat(MOST_POSITIVE, 1'b0);
    send_beat(MOST_NEGATIVE, 1'b1);
    send_beat(3, 1'b0);
    send_beat(-3, 1'b0);
    send_beat(3, 1'b1);
    // Store overflow: DEPTH entries are kept, then two more arrive. The last
    // one is dropped too but still starts the sort, and every beat of the run
    // must carry the dropped flag.
    for (k = 0; k < DEPTH + 2; k++) begin
      if (k < 4) begin
        send_beat(corner_value(k), 1'b0);
      end else if (k < DEPTH) begin
        send_beat(5000 - 300 * int'(k), 1'b0);
      end else begin
        send_beat(MOST_NEGATIVE + int'(k), k == DEPTH + 1);
      end
    end
    drain();

    // Phase one: fixed full passes, no idling, and a long receiver hold-off
    // at the start so that the block fills up and stalls its input. A write
    // to the unmapped index must leave the mode bit alone.
    apb_access(1'b1, EARLY_EXIT_ADDR, 32'h0000_0000);
    apb_access(1'b1, UNMAPPED_ADDR, 32'hFFFF_FFFF);
    apb_access(1'b0, EARLY_EXIT_ADDR, '0);
    hold_req <= 1'b1;
    run_phase(0, 0);

    // Phase two: early exit again, set by a write with every bit high since
    // only bit 0 counts. The sender idles most of the time.
    apb_access(1'b1, EARLY_EXIT_ADDR, 32'hFFFF_FFFF);
    apb_access(1'b0, EARLY_EXIT_ADDR, '0);
    run_phase(79, 0);

    // Phase three: full passes, with the upper bits of the write data high,
    // and a receiver that stalls most of the time.
    apb_access(1'b1, EARLY_EXIT_ADDR, 32'hFFFF_FFFE);
    apb_access(1'b0, EARLY_EXIT_ADDR, '0);
    run_phase(0, 79);

    // Phase four: early exit with moderate idling on both sides.
    apb_access(1'b1, EARLY_EXIT_ADDR, 32'h0000_0001);
    run_phase(31, 31);

    if (failures == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      if (pending != 0) begin
        $display("%0d sorted beats never arrived", pending);
      end
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
